// ===== rtl/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg: types and constants for the biased factor model SGD block
// Shared request, response and sequencer state types.
// ----------------------------------------------------------------------------
package bfm_pkg;

   localparam int NUM_USERS = 4096;
   localparam int NUM_ITEMS = 4096;
   localparam int FACTORS   = 16;

   localparam int UB_W  = $clog2(NUM_USERS);
   localparam int IB_W  = $clog2(NUM_ITEMS);
   localparam int F_W   = (FACTORS > 1) ? $clog2(FACTORS) : 1;
   localparam int FC_W  = $clog2(FACTORS + 1);
   localparam int UF_AW = $clog2(NUM_USERS * FACTORS);
   localparam int IF_AW = $clog2(NUM_ITEMS * FACTORS);

   localparam logic [22:0] ONE_Q20  = 23'd1048576;
   localparam logic [22:0] FIVE_Q20 = 23'd5242880;

   localparam logic [1:0] KIND_PREDICT = 2'd0;
   localparam logic [1:0] KIND_TRAIN   = 2'd1;
   localparam logic [1:0] KIND_LOAD_U  = 2'd2;
   localparam logic [1:0] KIND_LOAD_I  = 2'd3;

   localparam logic [1:0] REG_GMEAN = 2'd0;
   localparam logic [1:0] REG_LRATE = 2'd1;
   localparam logic [1:0] REG_REG   = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        user_id;
      logic [15:0]        item_id;
      logic [22:0]        rating;
      logic [3:0]         factor_index;
      logic signed [23:0] load_value;
   } req_type;

   typedef struct packed {
      logic [22:0] prediction;
      logic        ids_valid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BRD, ST_DOT_RD, ST_DOT_MAC, ST_PRED, ST_ERR,
      ST_B_REG, ST_B_LR, ST_B_WR, ST_F_RD, ST_F_MUL, ST_F_REG, ST_F_LR, ST_F_WR,
      ST_DONE
   } state_type;

   // multiplier operation selected by the sequencer
   typedef struct packed {
      logic signed [24:0] a;
      logic signed [27:0] b;
   } mul_op_type;

   function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
      if (x > 48'sd8388607) return 24'sh7FFFFF;
      if (x < -48'sd8388608) return 24'sh800000;
      return x[23:0];
   endfunction

endpackage

// ===== rtl/biased_factor_model_sgd.sv =====
// ----------------------------------------------------------------------------
// biased_factor_model_sgd: biased matrix factorisation with SGD updates
//
//  channel  | ports                      | transfer
//  req      | req_start/req_busy/req_data | start & !busy
//  rsp      | rsp_strobe/rsp_data        | one cycle, no stall
//  csr      | APB                        | psel & penable & pwrite
//
// Each request runs to its end before busy drops; train is paced by the one
// shared multiplier and the single read port of each factor memory.
// Reset clears the bias tables by a sweep over every entry, busy held high.
// The receiver cannot stall; a result is shown for one cycle.
// ----------------------------------------------------------------------------
module biased_factor_model_sgd (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_start,
   output logic                req_busy,
   input  bfm_pkg::req_type    req_data,
   output logic                rsp_strobe,
   output bfm_pkg::rsp_type    rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import bfm_pkg::*;

   localparam int CLR_W = (UB_W > IB_W) ? UB_W : IB_W;

   logic [22:0] gmean_ff;
   logic [19:0] lrate_ff, regw_ff;
   logic [1:0]  cidx;
   logic        cwr;

   assign csr_pready = 1'b1;
   assign cidx = csr_paddr[3:2];
   assign cwr  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gmean_ff <= 23'd3670016;
         lrate_ff <= 20'd10486;
         regw_ff  <= 20'd20972;
      end else if (cwr) begin
         case (cidx)
            REG_GMEAN: gmean_ff <= csr_pwdata[22:0];
            REG_LRATE: lrate_ff <= csr_pwdata[19:0];
            REG_REG:   regw_ff  <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cidx)
         REG_GMEAN: csr_prdata = {9'd0, gmean_ff};
         REG_LRATE: csr_prdata = {12'd0, lrate_ff};
         REG_REG:   csr_prdata = {12'd0, regw_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // memories
   logic signed [23:0] ubias_mem [NUM_USERS];
   logic signed [23:0] ibias_mem [NUM_ITEMS];
   logic signed [23:0] ufac_mem [NUM_USERS*FACTORS];
   logic signed [23:0] ifac_mem [NUM_ITEMS*FACTORS];

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CLR_W:0] clr_ff;
   logic [FC_W-1:0] f_ff;
   logic        bsel_ff;
   logic        phase_ff;
   logic signed [23:0] ub_ff, ib_ff, uf_ff, if_ff;
   logic signed [23:0] ubr_ff, ibr_ff, ufr_ff, ifr_ff;
   logic signed [50:0] acc_ff;
   logic signed [24:0] err_ff;
   logic signed [47:0] t_ff;
   logic signed [47:0] gradr;
   logic signed [47:0] t_f;
   logic [22:0] pred_ff;
   logic        uvalid, ivalid, clearing;
   logic [UF_AW-1:0] uaddr;
   logic [IF_AW-1:0] iaddr;
   mul_op_type op;
   logic signed [52:0] prod;

   bfm_mul u_mul (.clock(clock), .op(op), .prod_ff(prod));

   assign clearing = ~clr_ff[CLR_W];
   assign uvalid = {16'd0, req_ff.user_id} < 32'(NUM_USERS);
   assign ivalid = {16'd0, req_ff.item_id} < 32'(NUM_ITEMS);
   assign uaddr = UF_AW'(32'(req_ff.user_id[UB_W-1:0]) * FACTORS + 32'(f_ff[F_W-1:0]));
   assign iaddr = IF_AW'(32'(req_ff.item_id[IB_W-1:0]) * FACTORS + 32'(f_ff[F_W-1:0]));
   assign req_busy = (state_ff != ST_IDLE) | clearing;
   assign t_f = gradr - 48'(prod >>> 20);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_start && !clearing) state_in = ST_BRD;
         ST_BRD: begin
            if (req_ff.kind == KIND_LOAD_U || req_ff.kind == KIND_LOAD_I ||
                !uvalid || !ivalid) state_in = ST_DONE;
            else state_in = ST_DOT_RD;
         end
         ST_DOT_RD: state_in = ST_DOT_MAC;
         ST_DOT_MAC: state_in = (f_ff == FC_W'(FACTORS)) ? ST_PRED : ST_DOT_RD;
         ST_PRED:   state_in = (req_ff.kind == KIND_TRAIN) ? ST_ERR : ST_DONE;
         ST_ERR:    state_in = ST_B_REG;
         ST_B_REG:  state_in = ST_B_LR;
         ST_B_LR:   state_in = ST_B_WR;
         ST_B_WR:   state_in = bsel_ff ? ST_F_RD : ST_B_REG;
         ST_F_RD:   state_in = (f_ff == FC_W'(FACTORS)) ? ST_DONE : ST_F_MUL;
         ST_F_MUL:  state_in = ST_F_REG;
         ST_F_REG:  state_in = ST_F_LR;
         ST_F_LR:   state_in = ST_F_WR;
         ST_F_WR:   state_in = phase_ff ? ST_F_RD : ST_F_MUL;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // multiplier operands
   always_comb begin
      op.a = '0;
      op.b = '0;
      case (state_ff)
         ST_DOT_MAC: begin
            op.a = 25'(uf_ff);
            op.b = 28'(if_ff);
         end
         ST_ERR, ST_B_REG: begin
            op.a = $signed({5'd0, regw_ff});
            op.b = bsel_ff ? 28'(ibr_ff) : 28'(ubr_ff);
         end
         ST_B_WR: begin
            op.a = $signed({5'd0, regw_ff});
            op.b = 28'(ibr_ff);
         end
         ST_B_LR: begin
            op.a = $signed({5'd0, lrate_ff});
            op.b = 28'(t_ff);
         end
         ST_F_LR: begin
            op.a = $signed({5'd0, lrate_ff});
            op.b = 28'(t_f);
         end
         ST_F_MUL: begin
            op.a = err_ff;
            op.b = phase_ff ? 28'(ufr_ff) : 28'(ifr_ff);
         end
         ST_F_REG: begin
            op.a = $signed({5'd0, regw_ff});
            op.b = phase_ff ? 28'(ifr_ff) : 28'(ufr_ff);
         end
         default: ;
      endcase
   end

   // last product of the dot product is still in the multiplier register
   logic signed [50:0] dsum;
   logic signed [30:0] dsh;
   logic signed [47:0] pfull;
   assign dsum = acc_ff + 51'(prod);
   assign dsh = dsum[50:20];
   assign pfull = $signed({25'd0, gmean_ff}) + 48'(ub_ff) + 48'(ib_ff) + 48'(dsh);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         clr_ff     <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= (state_ff == ST_DONE);
         if (clearing) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         if (32'(clr_ff) < 32'(NUM_USERS)) ubias_mem[clr_ff[UB_W-1:0]] <= '0;
         if (32'(clr_ff) < 32'(NUM_ITEMS)) ibias_mem[clr_ff[IB_W-1:0]] <= '0;
      end
      ub_ff <= ubias_mem[req_ff.user_id[UB_W-1:0]];
      ib_ff <= ibias_mem[req_ff.item_id[IB_W-1:0]];
      uf_ff <= ufac_mem[uaddr];
      if_ff <= ifac_mem[iaddr];
      case (state_ff)
         ST_IDLE: begin
            req_ff  <= req_data;
            f_ff    <= '0;
            acc_ff  <= '0;
            bsel_ff <= 1'b0;
            phase_ff <= 1'b0;
         end
         ST_BRD: begin
            if (req_ff.kind == KIND_LOAD_U) begin
               pred_ff <= '0;
               if (uvalid && {12'd0, req_ff.factor_index} < 16'(FACTORS)) begin
                  ufac_mem[UF_AW'(32'(req_ff.user_id[UB_W-1:0]) * FACTORS +
                     32'(req_ff.factor_index))] <= req_ff.load_value;
                  rsp_data.ids_valid <= 1'b1;
               end else rsp_data.ids_valid <= 1'b0;
            end else if (req_ff.kind == KIND_LOAD_I) begin
               pred_ff <= '0;
               if (ivalid && {12'd0, req_ff.factor_index} < 16'(FACTORS)) begin
                  ifac_mem[IF_AW'(32'(req_ff.item_id[IB_W-1:0]) * FACTORS +
                     32'(req_ff.factor_index))] <= req_ff.load_value;
                  rsp_data.ids_valid <= 1'b1;
               end else rsp_data.ids_valid <= 1'b0;
            end else begin
               pred_ff <= gmean_ff;
               rsp_data.ids_valid <= uvalid & ivalid;
            end
            ubr_ff <= ubias_mem[req_ff.user_id[UB_W-1:0]];
            ibr_ff <= ibias_mem[req_ff.item_id[IB_W-1:0]];
         end
         ST_DOT_RD: f_ff <= f_ff + 1'b1;
         ST_DOT_MAC: ;
         ST_PRED: begin
            f_ff <= '0;
            if (pfull > $signed(48'(FIVE_Q20))) pred_ff <= FIVE_Q20;
            else if (pfull < $signed(48'(ONE_Q20))) pred_ff <= ONE_Q20;
            else pred_ff <= pfull[22:0];
         end
         ST_ERR: err_ff <= $signed({2'b0, req_ff.rating}) - $signed({2'b0, pred_ff});
         ST_B_REG: t_ff <= 48'(err_ff) - 48'(prod >>> 20);
         ST_B_LR: ;
         ST_B_WR: begin
            if (bsel_ff)
               ibias_mem[req_ff.item_id[IB_W-1:0]] <= sat24(48'(ibr_ff) + 48'(prod >>> 20));
            else
               ubias_mem[req_ff.user_id[UB_W-1:0]] <= sat24(48'(ubr_ff) + 48'(prod >>> 20));
            bsel_ff <= 1'b1;
         end
         ST_F_RD: begin
            ufr_ff <= ufac_mem[uaddr];
            ifr_ff <= ifac_mem[iaddr];
            phase_ff <= 1'b0;
         end
         ST_F_MUL: ;
         ST_F_REG: gradr <= 48'(prod >>> 20);
         ST_F_LR: t_ff <= t_f;
         ST_F_WR: begin
            if (phase_ff) begin
               ifac_mem[iaddr] <= sat24(48'(ifr_ff) + 48'(prod >>> 20));
               f_ff <= f_ff + 1'b1;
            end else
               ufac_mem[uaddr] <= sat24(48'(ufr_ff) + 48'(prod >>> 20));
            phase_ff <= ~phase_ff;
         end
         ST_DONE: rsp_data.prediction <= pred_ff;
         default: ;
      endcase
      // dot accumulate: product of the element read before the last ST_DOT_MAC
      if (state_ff == ST_DOT_RD && f_ff != '0) acc_ff <= acc_ff + 51'(prod);
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_DONE) else $error("strobe without done");
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_busy) else $error("idle during clear");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double result");
endmodule

// ===== rtl/bfm_mul.sv =====
// ----------------------------------------------------------------------------
// bfm_mul: shared registered multiplier
// One signed 25x28 product per cycle, result registered.
// ----------------------------------------------------------------------------
module bfm_mul (
   input  logic               clock,
   input  bfm_pkg::mul_op_type op,
   output logic signed [52:0] prod_ff
);
   import bfm_pkg::*;

   logic signed [52:0] prod_in;

   assign prod_in = op.a * op.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
